// ----- hw/rtl/lnf_pkg.sv -----
`timescale 1ns / 1ps
package lnf_pkg;

    localparam int unsigned CUR_W   = 24;
    localparam int unsigned V_W     = 32;
    localparam int unsigned GAIN_W  = 16;
    localparam int unsigned POS_W   = 31;
    localparam int unsigned PROD_W  = CUR_W + GAIN_W + 1;
    localparam int unsigned ACC_W   = 43;
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [IDX_W-1:0] REG_GAIN      = 3'd1;
    localparam logic [IDX_W-1:0] REG_DRAIN     = 3'd2;
    localparam logic [IDX_W-1:0] REG_KICK      = 3'd3;
    localparam logic [IDX_W-1:0] REG_SWING     = 3'd4;

    localparam logic signed [V_W-1:0]  THRESHOLD_RST = 32'sd32768;
    localparam logic [GAIN_W-1:0]      GAIN_RST      = 16'd256;
    localparam logic [POS_W-1:0]       DRAIN_RST     = 31'd0;
    localparam logic [POS_W-1:0]       KICK_RST      = 31'd0;
    localparam logic [POS_W-1:0]       SWING_RST     = 31'd65536;

    typedef struct packed {
        logic signed [V_W-1:0] threshold;
        logic [GAIN_W-1:0]     input_gain;
        logic [POS_W-1:0]      fire_drain;
        logic [POS_W-1:0]      feedback_kick;
        logic [POS_W-1:0]      reset_swing;
    } t_cfg;

    typedef struct packed {
        logic                  output_high;
        logic                  spiked;
        logic signed [V_W-1:0] membrane;
    } t_result;

endpackage

// ----- hw/rtl/lnf_fifo.sv -----
`timescale 1ns / 1ps
module lnf_fifo #(
    parameter int unsigned W = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_count;
    logic         w_do_push;
    logic         w_do_pop;

    assign o_full    = (r_count == 2'd2);
    assign o_empty   = (r_count == 2'd0);
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ----- hw/rtl/lnf_core.sv -----
`timescale 1ns / 1ps
module lnf_core (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    input  logic signed [lnf_pkg::CUR_W-1:0]        i_current,
    input  lnf_pkg::t_cfg                           i_cfg,
    input  logic                                    i_out_full,
    output logic                                    o_take,
    output lnf_pkg::t_result                        o_result
);

    localparam int unsigned AW = lnf_pkg::ACC_W;
    localparam int unsigned VW = lnf_pkg::V_W;

    logic signed [VW-1:0]                 r_membrane;
    logic                                 r_last;

    logic                                 w_high;
    logic signed [lnf_pkg::PROD_W-1:0]    w_prod;
    logic signed [AW-1:0]                 w_prior;
    logic signed [AW-1:0]                 w_thr;
    logic signed [AW-1:0]                 w_drain;
    logic signed [AW-1:0]                 w_kick;
    logic signed [AW-1:0]                 w_cand;
    logic signed [AW-1:0]                 w_next;
    logic signed [AW-1:0]                 w_swing;
    logic                                 w_up;
    logic                                 w_down;
    logic signed [VW-1:0]                 w_sat;

    assign o_take = i_valid && !i_out_full;
    assign w_high = (r_membrane > i_cfg.threshold);

    always_comb begin
        w_prod  = $signed(i_current) * $signed({1'b0, i_cfg.input_gain});
        w_prior = {{(AW-VW){r_membrane[VW-1]}}, r_membrane};
        w_thr   = {{(AW-VW){i_cfg.threshold[VW-1]}}, i_cfg.threshold};
        w_swing = {{(AW-lnf_pkg::POS_W){1'b0}}, i_cfg.reset_swing};
        w_drain = w_high ? {{(AW-lnf_pkg::POS_W){1'b0}}, i_cfg.fire_drain} : '0;
        if (w_high && !r_last) begin
            w_kick = {{(AW-lnf_pkg::POS_W){1'b0}}, i_cfg.feedback_kick};
        end else if (!w_high && r_last) begin
            w_kick = -{{(AW-lnf_pkg::POS_W){1'b0}}, i_cfg.feedback_kick};
        end else begin
            w_kick = '0;
        end
        w_cand = w_prior + {{(AW-lnf_pkg::PROD_W){w_prod[lnf_pkg::PROD_W-1]}}, w_prod}
                 - w_drain + w_kick;
        w_up   = (w_cand > w_thr) && (r_membrane <= i_cfg.threshold);
        w_down = (w_cand < w_thr) && (r_membrane >= i_cfg.threshold);
        priority if (w_up) begin
            w_next = w_thr + w_swing;
        end else if (w_down) begin
            w_next = w_thr - w_swing;
        end else begin
            w_next = w_cand;
        end
        // clamp to signed 32-bit range
        if (!w_next[AW-1] && (w_next[AW-2:VW-1] != '0)) begin
            w_sat = {1'b0, {(VW-1){1'b1}}};
        end else if (w_next[AW-1] && (w_next[AW-2:VW-1] != '1)) begin
            w_sat = {1'b1, {(VW-1){1'b0}}};
        end else begin
            w_sat = w_next[VW-1:0];
        end
    end

    always_comb begin
        o_result.output_high = w_high;
        o_result.spiked      = w_up || w_down;
        o_result.membrane    = w_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_membrane <= '0;
            r_last     <= 1'b0;
        end else if (o_take) begin
            r_membrane <= w_sat;
            r_last     <= w_high;
        end
    end

endmodule

// ----- hw/rtl/lif_neuron_feedback_step_unit.sv -----
`timescale 1ns / 1ps
// An item pushed into the input queue passes the core combinationally and is
// then registered in the result queue, where its result is visible (empty low)
// and can be popped. Throughput: one item per cycle while the result queue is
// not full; the core's membrane update (multiply-add, compare, clamp) is
// combinational. Reset (synchronous, active low): queues empty, membrane and
// output bit zero, registers back to their default values.
module lif_neuron_feedback_step_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [lnf_pkg::CUR_W-1:0]    i_iin_current,
    output logic                                empty,
    input  logic                                pop,
    output logic                                o_output_high,
    output logic                                o_spiked,
    output logic signed [lnf_pkg::V_W-1:0]      o_membrane,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lnf_pkg::ADDR_W-1:0]          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int unsigned RW = $bits(lnf_pkg::t_result);

    lnf_pkg::t_cfg                      r_cfg;
    logic [lnf_pkg::IDX_W-1:0]          w_idx;
    logic                               w_cfg_wr;

    logic                               w_in_empty;
    logic [lnf_pkg::CUR_W-1:0]          w_in_data;
    logic                               w_take;
    logic                               w_out_full;
    lnf_pkg::t_result                   w_core_res;
    lnf_pkg::t_result                   w_out_res;

    assign pready   = 1'b1;
    assign w_idx    = paddr[lnf_pkg::ADDR_W-1:2];
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold     <= lnf_pkg::THRESHOLD_RST;
            r_cfg.input_gain    <= lnf_pkg::GAIN_RST;
            r_cfg.fire_drain    <= lnf_pkg::DRAIN_RST;
            r_cfg.feedback_kick <= lnf_pkg::KICK_RST;
            r_cfg.reset_swing   <= lnf_pkg::SWING_RST;
        end else if (w_cfg_wr) begin
            unique case (w_idx)
                lnf_pkg::REG_THRESHOLD: r_cfg.threshold     <= pwdata;
                lnf_pkg::REG_GAIN:      r_cfg.input_gain    <= pwdata[lnf_pkg::GAIN_W-1:0];
                lnf_pkg::REG_DRAIN:     r_cfg.fire_drain    <= pwdata[lnf_pkg::POS_W-1:0];
                lnf_pkg::REG_KICK:      r_cfg.feedback_kick <= pwdata[lnf_pkg::POS_W-1:0];
                lnf_pkg::REG_SWING:     r_cfg.reset_swing   <= pwdata[lnf_pkg::POS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            lnf_pkg::REG_THRESHOLD: prdata = r_cfg.threshold;
            lnf_pkg::REG_GAIN:      prdata = {16'd0, r_cfg.input_gain};
            lnf_pkg::REG_DRAIN:     prdata = {1'b0, r_cfg.fire_drain};
            lnf_pkg::REG_KICK:      prdata = {1'b0, r_cfg.feedback_kick};
            lnf_pkg::REG_SWING:     prdata = {1'b0, r_cfg.reset_swing};
            default:                prdata = '0;
        endcase
    end

    // front: input item queue
    lnf_fifo #(
        .W (lnf_pkg::CUR_W)
    ) u_in_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (i_iin_current),
        .o_full  (full),
        .i_pop   (w_take),
        .o_empty (w_in_empty),
        .o_data  (w_in_data)
    );

    lnf_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (!w_in_empty),
        .i_current  ($signed(w_in_data)),
        .i_cfg      (r_cfg),
        .i_out_full (w_out_full),
        .o_take     (w_take),
        .o_result   (w_core_res)
    );

    // back: result queue
    lnf_fifo #(
        .W (RW)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_take),
        .i_data  (w_core_res),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (w_out_res)
    );

    assign o_output_high = w_out_res.output_high;
    assign o_spiked      = w_out_res.spiked;
    assign o_membrane    = w_out_res.membrane;

endmodule
